>>> hdl/ccskc_pkg.sv
package ccskc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int NUM_KW = 44;
  localparam int KW_IDX_W = 6;
  localparam int KW_MAX_LEN = 14;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_EOL = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [2:0] OUT_CHAR = 3'd0;
  localparam logic [2:0] OUT_EOL = 3'd1;
  localparam logic [2:0] OUT_LINE_CNT = 3'd2;
  localparam logic [2:0] OUT_BLOCK_CNT = 3'd3;
  localparam logic [2:0] OUT_KW_CNT = 3'd4;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0] out_kind;
    logic [31:0] value;
    logic [5:0] keyword_index;
    logic last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic step_char;   // process the input byte (char transaction)
    logic step_eol;    // close the line
    logic rpt_load;    // capture report read position 0
    logic rpt_advance; // move to next report entry
  } ccskc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rpt_done;    // current report entry is the final one
  } ccskc_stat_t;

  // keyword text, 14 bytes, first char in the top byte, zero padded
  function automatic logic [111:0] kw_text(input logic [5:0] k);
    logic [111:0] t;
    t = '0;
    case (k)
      6'd0: t = {"_Alignas", 48'h0};
      6'd1: t = {"_Alignof", 48'h0};
      6'd2: t = {"_Atomic", 56'h0};
      6'd3: t = {"_Bool", 72'h0};
      6'd4: t = {"_Complex", 48'h0};
      6'd5: t = {"_Generic", 48'h0};
      6'd6: t = {"_Imaginary", 32'h0};
      6'd7: t = {"_Noreturn", 40'h0};
      6'd8: t = {"_Static", "_assert"};
      6'd9: t = {"_Thread", "_local", 8'h0};
      6'd10: t = {"auto", 80'h0};
      6'd11: t = {"break", 72'h0};
      6'd12: t = {"case", 80'h0};
      6'd13: t = {"char", 80'h0};
      6'd14: t = {"const", 72'h0};
      6'd15: t = {"continue", 48'h0};
      6'd16: t = {"default", 56'h0};
      6'd17: t = {"do", 96'h0};
      6'd18: t = {"double", 64'h0};
      6'd19: t = {"else", 80'h0};
      6'd20: t = {"enum", 80'h0};
      6'd21: t = {"extern", 64'h0};
      6'd22: t = {"float", 72'h0};
      6'd23: t = {"for", 88'h0};
      6'd24: t = {"goto", 80'h0};
      6'd25: t = {"if", 96'h0};
      6'd26: t = {"inline", 64'h0};
      6'd27: t = {"int", 88'h0};
      6'd28: t = {"long", 80'h0};
      6'd29: t = {"register", 48'h0};
      6'd30: t = {"restrict", 48'h0};
      6'd31: t = {"return", 64'h0};
      6'd32: t = {"short", 72'h0};
      6'd33: t = {"signed", 64'h0};
      6'd34: t = {"sizeof", 64'h0};
      6'd35: t = {"static", 64'h0};
      6'd36: t = {"struct", 64'h0};
      6'd37: t = {"switch", 64'h0};
      6'd38: t = {"typedef", 56'h0};
      6'd39: t = {"union", 72'h0};
      6'd40: t = {"unsigned", 48'h0};
      6'd41: t = {"void", 80'h0};
      6'd42: t = {"volatile", 48'h0};
      6'd43: t = {"while", 72'h0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [5:0] k);
    logic [111:0] t;
    logic [3:0] n;
    t = kw_text(k);
    n = '0;
    for (int i = 0; i < KW_MAX_LEN; i++) begin
      if (t[111 - 8 * i -: 8] != 8'h00) n = 4'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [5:0] k, input logic [3:0] p);
    logic [111:0] t;
    logic [7:0] c;
    t = kw_text(k);
    c = 8'h00;
    for (int i = 0; i < KW_MAX_LEN; i++) begin
      if (p == 4'(i)) c = t[111 - 8 * i -: 8];
    end
    return c;
  endfunction

  function automatic logic [31:0] clip32(input logic [COUNT_WIDTH-1:0] v);
    logic [31:0] r;
    if (COUNT_WIDTH > 32) begin
      r = (v > COUNT_WIDTH'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(v);
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

>>> hdl/c_comment_strip_keyword_count.sv
// channel | signals                          | payload
// in      | in_valid / in_ready / in_data    | in_item_t  (kind, char_code)
// out     | out_valid / out_ready / out_data | out_item_t (out_kind, value, index, last)
//
// A byte or end of line is taken in and gives up to two results;
// a pending second result holds the input off until it is shown.
// A report request gives 46 results, one per cycle unless the output stalls, with keyword counts read
// one ahead from the count memory; input is held off meanwhile.
// Reset is synchronous; it clears all counters and the comment state.
// Output stalls hold the result register and back up into in_ready.
module c_comment_strip_keyword_count (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ccskc_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ccskc_pkg::out_item_t  out_data
);
  import ccskc_pkg::*;

  ccskc_cmd_t  cmd;
  ccskc_stat_t stat;
  logic        out_show_rpt, out_load_item, ready_ctrl;
  logic        pend_block;

  ccskc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid && !pend_block), .in_ready(ready_ctrl), .in_data(in_data),
    .out_ready(out_ready), .out_show_rpt(out_show_rpt),
    .out_load_item(out_load_item), .cmd(cmd), .stat(stat), .out_valid(out_valid)
  );

  ccskc_dp u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .cmd(cmd), .stat(stat),
    .out_load_item(out_load_item), .out_show_rpt(out_show_rpt),
    .out_ready(out_ready), .out_valid(out_valid), .out_data(out_data)
  );

  // hold input while a second result is still pending
  assign pend_block = out_valid && !out_data.last;
  assign in_ready = ready_ctrl && !pend_block;

endmodule

>>> hdl/ccskc_ctrl.sv
module ccskc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ccskc_pkg::in_item_t    in_data,
  input  logic                   out_ready,
  output logic                   out_show_rpt,
  output logic                   out_load_item,
  output ccskc_pkg::ccskc_cmd_t  cmd,
  input  ccskc_pkg::ccskc_stat_t stat,
  input  logic                   out_valid
);
  import ccskc_pkg::*;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_RPT = 2'd1;

  logic [1:0] state, state_next;
  logic       accept;
  logic       out_free;

  // output register free when empty or being drained
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_RUN) && out_free;
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    out_load_item = 1'b0;
    out_show_rpt = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (accept) begin
          case (in_data.kind)
            KIND_CHAR: cmd.step_char = 1'b1;
            KIND_EOL: cmd.step_eol = 1'b1;
            KIND_REPORT: begin
              cmd.rpt_load = 1'b1;
              state_next = ST_RPT;
            end
            default: ;
          endcase
          out_load_item = 1'b1;
        end
      end
      ST_RPT: begin
        if (out_free) begin
          out_show_rpt = 1'b1;
          cmd.rpt_advance = 1'b1;
          if (stat.rpt_done) state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/ccskc_dp.sv
module ccskc_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  ccskc_pkg::in_item_t    in_data,
  input  ccskc_pkg::ccskc_cmd_t  cmd,
  output ccskc_pkg::ccskc_stat_t stat,
  input  logic                   out_load_item,
  input  logic                   out_show_rpt,
  input  logic                   out_ready,
  output logic                   out_valid,
  output ccskc_pkg::out_item_t   out_data
);
  import ccskc_pkg::*;

  logic                   in_block, held_valid, skip_line, quote_seen, token_overlong;
  logic [7:0]             held_char;
  logic [NUM_KW-1:0]      candidates;
  logic [3:0]             token_position;
  logic [COUNT_WIDTH-1:0] line_total, block_total;

  // keyword counts: one memory, one read and one write per cycle
  logic [COUNT_WIDTH-1:0] kw_mem [NUM_KW];
  logic [NUM_KW-1:0]      kw_seen;
  logic                   hit_any;
  logic [5:0]             hit_idx;
  logic                   inc_v, wr_v;
  logic [5:0]             inc_idx, wr_idx;
  logic [5:0]             rd_addr;
  logic [COUNT_WIDTH-1:0] rd_data, cur_cnt, wr_val;
  logic                   rd_seen;

  logic                   in_block_next, held_valid_next, skip_line_next, quote_seen_next;
  logic                   token_overlong_next;
  logic [7:0]             held_char_next;
  logic [NUM_KW-1:0]      cand_next;
  logic [3:0]             pos_next;
  logic                   line_inc, block_inc;
  logic [NUM_KW-1:0]      kw_hit;

  // up to two emitted bytes per transaction
  logic                   em0_v, em1_v;
  logic [7:0]             em0_c, em1_c;

  logic [5:0]             rpt_pos, rpt_pos_next;
  logic                   out_pend_v;
  out_item_t              pend_item;
  logic                   pend_v;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // one stripped byte through the tokenizer, returns updated token state
  typedef struct packed {
    logic              quote;
    logic [NUM_KW-1:0] cand;
    logic [3:0]        pos;
    logic              over;
    logic [NUM_KW-1:0] hit;
  } tok_t;

  function automatic tok_t tok_end(input tok_t s);
    tok_t r;
    r = s;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!s.over && s.pos != 4'd0 && s.cand[k] && kw_len(6'(k)) == s.pos) r.hit[k] = 1'b1;
    end
    r.cand = '1;
    r.pos = '0;
    r.over = 1'b0;
    return r;
  endfunction

  function automatic tok_t tok_byte(input tok_t s, input logic [7:0] c);
    tok_t r;
    r = s;
    if (s.quote) begin
      r = tok_end(s);
    end else if (c == CH_QUOTE) begin
      r = tok_end(s);
      r.quote = 1'b1;
    end else if (is_blank(c)) begin
      r = tok_end(s);
    end else if (s.pos == 4'd15) begin
      r.over = 1'b1;
      r.cand = '0;
    end else begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (s.pos >= kw_len(6'(k)) || kw_char(6'(k), s.pos) != c) r.cand[k] = 1'b0;
      end
      r.pos = s.pos + 4'd1;
    end
    return r;
  endfunction

  tok_t t0, t1, t2, t3;

  always_comb begin
    logic [7:0] c;
    logic       ib;
    c = in_data.char_code;
    in_block_next = in_block;
    held_valid_next = held_valid;
    held_char_next = held_char;
    skip_line_next = skip_line;
    line_inc = 1'b0;
    block_inc = 1'b0;
    em0_v = 1'b0;
    em0_c = held_char;
    em1_v = 1'b0;
    em1_c = c;
    ib = in_block;
    if (cmd.step_char && !skip_line) begin
      if (!held_valid) begin
        if (c == CH_SLASH || (ib && c == CH_STAR)) begin
          held_valid_next = 1'b1;
          held_char_next = c;
        end else if (!ib) begin
          em1_v = 1'b1;
        end
      end else begin
        held_valid_next = 1'b0;
        if (held_char == CH_SLASH && c == CH_SLASH) begin
          line_inc = 1'b1;
          skip_line_next = 1'b1;
        end else if (!ib && held_char == CH_SLASH && c == CH_STAR) begin
          in_block_next = 1'b1;
          block_inc = 1'b1;
        end else if (ib && held_char == CH_STAR && c == CH_SLASH) begin
          in_block_next = 1'b0;
        end else begin
          em0_v = !ib;
          if (c == CH_SLASH || (ib && c == CH_STAR)) begin
            held_valid_next = 1'b1;
            held_char_next = c;
          end else if (!ib) begin
            em1_v = 1'b1;
          end
        end
      end
    end
    if (cmd.step_eol) begin
      em0_v = held_valid && !skip_line && !in_block;
      held_valid_next = 1'b0;
      skip_line_next = 1'b0;
    end
  end

  always_comb begin
    t0.quote = quote_seen;
    t0.cand = candidates;
    t0.pos = token_position;
    t0.over = token_overlong;
    t0.hit = '0;
    t1 = em0_v ? tok_byte(t0, em0_c) : t0;
    t2 = em1_v ? tok_byte(t1, em1_c) : t1;
    t3 = cmd.step_eol ? tok_end(t2) : t2;
    quote_seen_next = cmd.step_eol ? 1'b0 : t3.quote;
    cand_next = t3.cand;
    pos_next = t3.pos;
    token_overlong_next = t3.over;
    kw_hit = t3.hit;
  end

  // at most one keyword ends per transaction
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_hit[k]) begin
        hit_any = 1'b1;
        hit_idx = 6'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_block <= 1'b0;
      held_valid <= 1'b0;
      held_char <= 8'h00;
      skip_line <= 1'b0;
      quote_seen <= 1'b0;
      candidates <= '1;
      token_position <= '0;
      token_overlong <= 1'b0;
      line_total <= '0;
      block_total <= '0;
    end else begin
      if (cmd.step_char || cmd.step_eol) begin
        in_block <= in_block_next;
        held_valid <= held_valid_next;
        held_char <= held_char_next;
        skip_line <= skip_line_next;
        quote_seen <= quote_seen_next;
        candidates <= cand_next;
        token_position <= pos_next;
        token_overlong <= token_overlong_next;
        if (line_inc && line_total != '1) line_total <= line_total + 1'b1;
        if (block_inc && block_total != '1) block_total <= block_total + 1'b1;
      end
    end
  end

  // keyword count update: capture hit, read count, write count + 1
  always_ff @(posedge clk) begin
    if (rst) begin
      inc_v <= 1'b0;
      inc_idx <= '0;
      wr_v <= 1'b0;
      wr_idx <= '0;
    end else begin
      inc_v <= (cmd.step_char || cmd.step_eol) && hit_any;
      inc_idx <= hit_idx;
      wr_v <= inc_v;
      wr_idx <= inc_idx;
    end
  end

  assign cur_cnt = rd_seen ? rd_data : '0;
  assign wr_val = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;

  // report walk: position 0 line count, 1 block count, 2.. keywords
  always_comb begin
    rpt_pos_next = rpt_pos;
    if (cmd.rpt_load) begin
      rpt_pos_next = '0;
    end else if (cmd.rpt_advance) begin
      rpt_pos_next = rpt_pos + 6'd1;
    end
  end

  // report reads one entry ahead so the count is registered when shown
  always_comb begin
    if (inc_v) begin
      rd_addr = inc_idx;
    end else if (rpt_pos_next >= 6'd2 && rpt_pos_next < 6'(NUM_KW + 2)) begin
      rd_addr = rpt_pos_next - 6'd2;
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_v) kw_mem[wr_idx] <= wr_val;
    if (wr_v && wr_idx == rd_addr) rd_data <= wr_val;
    else rd_data <= kw_mem[rd_addr];
  end

  // entries read as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      kw_seen <= '0;
      rd_seen <= 1'b0;
    end else begin
      if (wr_v) kw_seen[wr_idx] <= 1'b1;
      rd_seen <= (wr_v && wr_idx == rd_addr) || kw_seen[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_pos <= '0;
    end else begin
      rpt_pos <= rpt_pos_next;
    end
  end

  assign stat.rpt_done = (rpt_pos == 6'(NUM_KW + 1));

  out_item_t rpt_item;
  always_comb begin
    logic [5:0] ki;
    ki = rpt_pos - 6'd2;
    rpt_item = '0;
    if (rpt_pos == 6'd0) begin
      rpt_item.out_kind = OUT_LINE_CNT;
      rpt_item.value = clip32(line_total);
    end else if (rpt_pos == 6'd1) begin
      rpt_item.out_kind = OUT_BLOCK_CNT;
      rpt_item.value = clip32(block_total);
    end else begin
      rpt_item.out_kind = OUT_KW_CNT;
      rpt_item.value = clip32(cur_cnt);
      rpt_item.keyword_index = ki;
    end
    rpt_item.last = stat.rpt_done;
  end

  // second result (EOL marker or second byte) waits in a pending slot
  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign out_pend_v = pend_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_v <= 1'b0;
    end else begin
      if (out_show_rpt) begin
        out_valid <= 1'b1;
        out_data <= rpt_item;
      end else if (out_pend_v && out_free) begin
        out_valid <= 1'b1;
        out_data <= pend_item;
        pend_v <= 1'b0;
      end else if (out_load_item && (em0_v || em1_v || cmd.step_eol)) begin
        out_valid <= 1'b1;
        if (cmd.step_eol) begin
          if (em0_v) begin
            out_data <= '{OUT_CHAR, {24'h0, em0_c}, 6'd0, 1'b0};
            pend_item <= '{OUT_EOL, 32'h0, 6'd0, 1'b1};
            pend_v <= 1'b1;
          end else begin
            out_data <= '{OUT_EOL, 32'h0, 6'd0, 1'b1};
          end
        end else if (em0_v && em1_v) begin
          out_data <= '{OUT_CHAR, {24'h0, em0_c}, 6'd0, 1'b0};
          pend_item <= '{OUT_CHAR, {24'h0, em1_c}, 6'd0, 1'b1};
          pend_v <= 1'b1;
        end else if (em0_v) begin
          out_data <= '{OUT_CHAR, {24'h0, em0_c}, 6'd0, 1'b1};
        end else begin
          out_data <= '{OUT_CHAR, {24'h0, em1_c}, 6'd0, 1'b1};
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/ccskc_checker.sv
module ccskc_props (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input ccskc_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input ccskc_pkg::out_item_t out_data
);
  import ccskc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.out_kind <= OUT_KW_CNT))
    else $error("bad out_kind");

  a_kw_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_kind != OUT_KW_CNT |-> out_data.keyword_index == 6'd0)
    else $error("index set on non keyword result");

  a_no_take_midreport: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_kind == OUT_KW_CNT && !out_data.last |-> !in_ready)
    else $error("input taken during report");

  a_char_upper: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_kind == OUT_CHAR |-> out_data.value[31:8] == 24'h0)
    else $error("char result too wide");

endmodule

bind c_comment_strip_keyword_count ccskc_props u_chk (.*);
